// ===== src/cllc_pkg.sv =====
package cllc_pkg;

   localparam int LuxWidth = 18;

   typedef enum logic [1:0] {
      CMD_TICK   = 2'd0,
      CMD_STATUS = 2'd1,
      CMD_CHANGE = 2'd2,
      CMD_NONE   = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      MODE_IDLE     = 2'd0,
      MODE_SAMPLING = 2'd1,
      MODE_ACTIVE   = 2'd2,
      MODE_UNUSED   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      CSR_ENABLE      = 3'd0,
      CSR_LOWEST      = 3'd1,
      CSR_HIGHEST     = 3'd2,
      CSR_DOUBLE_DOWN = 3'd3,
      CSR_DOUBLE_UP   = 3'd4,
      CSR_CONFIRM     = 3'd5,
      CSR_LOCKOUT     = 3'd6,
      CSR_SPARE       = 3'd7
   } csr_index_type;

   localparam logic [LuxWidth-1:0] LuxLimit = LuxWidth'(160000);

   typedef struct packed {
      logic [1:0]          command;
      logic [LuxWidth-1:0] lux;
      logic                read_ok;
      logic [3:0]          level_now;
      logic                lamps_on;
   } req_type;

   typedef struct packed {
      logic                set_level;
      logic [3:0]          new_level;
      logic [1:0]          mode;
      logic [LuxWidth-1:0] baseline;
   } rsp_type;

endpackage

// ===== src/cllc_ram.sv =====
module cllc_ram #(
   parameter int Width = 18,
   parameter int Depth = 30
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== src/constant_light_level_controller.sv =====
// Constant light level controller. Requests are light ticks, lamp status
// updates and external change events; each gives exactly one response that
// carries the mode and baseline after the request. A new request is accepted
// only once the response to the last one has been registered. On the tick
// that completes a sampling round, the median is found by ranking every
// stored sample against all stored samples through the single read port of
// the sample memory, followed by a pass over the last STABLE_WINDOW samples
// (all of them if STABLE_WINDOW exceeds SAMPLE_COUNT) for the stability check.
module constant_light_level_controller #(
   parameter int SAMPLE_COUNT  = 30,
   parameter int STABLE_WINDOW = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cllc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cllc_pkg::rsp_type rsp_data,
   input  logic              csr_write,
   input  logic [2:0]        csr_index,
   input  logic [5:0]        csr_data
);
   import cllc_pkg::*;

   localparam int AW  = $clog2(SAMPLE_COUNT);
   localparam int CW  = $clog2(SAMPLE_COUNT + 1);
   localparam int Win = (STABLE_WINDOW < SAMPLE_COUNT) ? STABLE_WINDOW : SAMPLE_COUNT;
   localparam int Lo  = SAMPLE_COUNT / 2 - 1;
   localparam int Hi  = SAMPLE_COUNT / 2;
   localparam bit Even = (SAMPLE_COUNT % 2) == 0;
   localparam int PW  = LuxWidth + 5;

   typedef enum logic [3:0] {
      ST_IDLE, ST_EXEC, ST_RD_I, ST_WAIT_I, ST_RD_J, ST_CMP_J, ST_RANK,
      ST_MED, ST_RD_S, ST_CMP_S, ST_FINISH, ST_TGT, ST_OUT
   } state_type;

   state_type state_ff;
   req_type   req_ff;
   logic enable_ff;
   logic [3:0] lowest_ff, highest_ff, ddown_ff, dup_ff, confirm_ff;
   logic [5:0] lockout_ff, lock_ff;
   mode_type mode_ff;
   logic [CW-1:0] index_ff;
   logic [LuxWidth-1:0] base_ff, vi_ff, lo_ff, hi_ff;
   logic [3:0] agree_ff, pend_ff;
   logic pend_valid_ff, stable_ff;
   logic [AW-1:0] i_ff, j_ff;
   logic [CW-1:0] less_ff, leq_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff;
   logic set_ff;
   logic [3:0] new_level_ff;

   logic wr_en;
   logic [AW-1:0] rd_addr;
   logic [LuxWidth-1:0] rd_data;
   logic ok;
   logic [LuxWidth:0] med_sum;
   logic [PW-1:0] s10, b9, b11, d, d10, d20, b3;
   logic [3:0] tgt, lvl;

   cllc_ram #(.Width(LuxWidth), .Depth(SAMPLE_COUNT)) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(index_ff[AW-1:0]),
      .wr_data(req_ff.lux),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign ok = req_ff.read_ok && (req_ff.lux <= LuxLimit);
   assign lvl = req_ff.level_now;
   assign wr_en = (state_ff == ST_EXEC) && (req_ff.command == CMD_TICK)
                  && (mode_ff == MODE_SAMPLING) && ok;
   assign rd_addr = (state_ff == ST_RD_I) ? i_ff : j_ff;
   assign med_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign b9  = PW'(base_ff) * PW'(9);
   assign b11 = PW'(base_ff) * PW'(11);
   assign b3  = PW'(base_ff) * PW'(3);
   assign s10 = PW'(((state_ff == ST_TGT) ? req_ff.lux : rd_data)) * PW'(10);
   assign d   = (req_ff.lux > base_ff) ? PW'(req_ff.lux - base_ff) : PW'(base_ff - req_ff.lux);
   assign d10 = d * PW'(10);
   assign d20 = d * PW'(20);

   always_comb begin
      logic big_step;
      big_step = d10 > b3;
      tgt = lvl;
      if (d20 >= b3) begin
         if (s10 > b11) begin
            if (big_step && lvl > ddown_ff) begin
               tgt = (lvl >= 4'd2) ? lvl - 4'd2 : 4'd0;
            end else if (lvl > lowest_ff) begin
               tgt = lvl - 4'd1;
            end
         end else if (s10 < b9) begin
            if (big_step && lvl < dup_ff) begin
               tgt = (lvl <= 4'd13) ? lvl + 4'd2 : 4'd15;
            end else if (lvl < highest_ff) begin
               tgt = lvl + 4'd1;
            end
         end
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         enable_ff <= 1'b0;
         lowest_ff <= 4'd0;
         highest_ff <= 4'd4;
         ddown_ff <= 4'd1;
         dup_ff <= 4'd3;
         confirm_ff <= 4'd3;
         lockout_ff <= 6'd6;
         mode_ff <= MODE_IDLE;
         index_ff <= '0;
         base_ff <= '0;
         agree_ff <= 4'd0;
         pend_ff <= 4'd0;
         pend_valid_ff <= 1'b0;
         lock_ff <= 6'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index_type'(csr_index))
               CSR_ENABLE:      enable_ff <= csr_data[0];
               CSR_LOWEST:      lowest_ff <= csr_data[3:0];
               CSR_HIGHEST:     highest_ff <= csr_data[3:0];
               CSR_DOUBLE_DOWN: ddown_ff <= csr_data[3:0];
               CSR_DOUBLE_UP:   dup_ff <= csr_data[3:0];
               CSR_CONFIRM:     confirm_ff <= csr_data[3:0];
               CSR_LOCKOUT:     lockout_ff <= csr_data;
               default: ;
            endcase
         end
         if (state_ff == ST_OUT && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  req_ff <= req_data;
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               set_ff <= 1'b0;
               new_level_ff <= 4'd0;
               state_ff <= ST_OUT;
               unique case (command_type'(req_ff.command))
                  CMD_TICK: begin
                     if (mode_ff == MODE_SAMPLING && ok) begin
                        index_ff <= index_ff + CW'(1);
                        if (index_ff == CW'(SAMPLE_COUNT - 1)) begin
                           i_ff <= '0;
                           state_ff <= ST_RD_I;
                        end
                     end else if (mode_ff == MODE_ACTIVE) begin
                        if (lock_ff != 6'd0) begin
                           lock_ff <= lock_ff - 6'd1;
                        end else if (!ok) begin
                           agree_ff <= 4'd0;
                        end else begin
                           state_ff <= ST_TGT;
                        end
                     end
                  end
                  CMD_STATUS: begin
                     if (enable_ff) begin
                        if (mode_ff == MODE_IDLE) begin
                           if (req_ff.lamps_on) begin
                              mode_ff <= MODE_SAMPLING;
                              index_ff <= '0;
                           end
                        end else if (!req_ff.lamps_on) begin
                           mode_ff <= MODE_IDLE;
                           index_ff <= '0;
                           lock_ff <= 6'd0;
                           agree_ff <= 4'd0;
                           pend_valid_ff <= 1'b0;
                           pend_ff <= 4'd0;
                        end
                     end
                  end
                  CMD_CHANGE: begin
                     if (enable_ff && mode_ff == MODE_ACTIVE) begin
                        mode_ff <= MODE_SAMPLING;
                        index_ff <= '0;
                        agree_ff <= 4'd0;
                        pend_valid_ff <= 1'b0;
                        pend_ff <= 4'd0;
                     end
                  end
                  default: ;
               endcase
            end
            ST_RD_I: state_ff <= ST_WAIT_I;
            ST_WAIT_I: begin
               vi_ff <= rd_data;
               state_ff <= ST_RD_J;
               j_ff <= '0;
               less_ff <= '0;
               leq_ff <= '0;
            end
            ST_RD_J: state_ff <= ST_CMP_J;
            ST_CMP_J: begin
               if (rd_data < vi_ff) less_ff <= less_ff + CW'(1);
               if (rd_data <= vi_ff) leq_ff <= leq_ff + CW'(1);
               if (j_ff == AW'(SAMPLE_COUNT - 1)) begin
                  state_ff <= ST_RANK;
               end else begin
                  j_ff <= j_ff + AW'(1);
                  state_ff <= ST_RD_J;
               end
            end
            ST_RANK: begin
               if (less_ff <= CW'(Lo) && leq_ff > CW'(Lo)) lo_ff <= vi_ff;
               if (less_ff <= CW'(Hi) && leq_ff > CW'(Hi)) hi_ff <= vi_ff;
               if (i_ff == AW'(SAMPLE_COUNT - 1)) begin
                  state_ff <= ST_MED;
               end else begin
                  i_ff <= i_ff + AW'(1);
                  state_ff <= ST_RD_I;
               end
            end
            ST_MED: begin
               base_ff <= Even ? med_sum[LuxWidth:1] : hi_ff;
               stable_ff <= 1'b1;
               j_ff <= AW'(SAMPLE_COUNT - Win);
               state_ff <= ST_RD_S;
            end
            ST_RD_S: state_ff <= ST_CMP_S;
            ST_CMP_S: begin
               if (s10 < b9 || s10 > b11) stable_ff <= 1'b0;
               if (j_ff == AW'(SAMPLE_COUNT - 1)) begin
                  state_ff <= ST_FINISH;
               end else begin
                  j_ff <= j_ff + AW'(1);
                  state_ff <= ST_RD_S;
               end
            end
            ST_FINISH: begin
               if (stable_ff && base_ff >= LuxWidth'(16)) begin
                  mode_ff <= MODE_ACTIVE;
               end else begin
                  index_ff <= '0;
               end
               state_ff <= ST_OUT;
            end
            ST_TGT: begin
               if (tgt != lvl) begin
                  if (pend_valid_ff && pend_ff == tgt) begin
                     if ((agree_ff == 4'd15 ? agree_ff : agree_ff + 4'd1) >= confirm_ff) begin
                        set_ff <= 1'b1;
                        new_level_ff <= tgt;
                        agree_ff <= 4'd0;
                        pend_valid_ff <= 1'b0;
                        pend_ff <= 4'd0;
                        lock_ff <= lockout_ff;
                     end else begin
                        agree_ff <= agree_ff + 4'd1;
                     end
                  end else begin
                     pend_ff <= tgt;
                     pend_valid_ff <= 1'b1;
                     agree_ff <= 4'd1;
                  end
               end else begin
                  agree_ff <= 4'd0;
                  pend_valid_ff <= 1'b0;
                  pend_ff <= 4'd0;
               end
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_ff.set_level <= set_ff;
                  rsp_ff.new_level <= new_level_ff;
                  rsp_ff.mode <= mode_ff;
                  rsp_ff.baseline <= base_ff;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
